// ----- design/ncc_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-center classifier package
// Shared widths, codes and types for the controller and the datapath.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int ELEM_BITS  = 16;
    localparam int N_ELEMS    = 9;
    localparam int SLOT_W     = 4;
    localparam int NUMC_W     = 5;
    localparam int IDX_OUT_W  = 4;
    localparam int MAG_W      = ELEM_BITS;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int PSUM_W     = SQ_W + 2;
    localparam int DIST_W     = 36;
    localparam int S_TDATA_W  = 152;
    localparam int M_TDATA_W  = IDX_OUT_W + DIST_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic FUNC_LOAD       = 1'b0;
    localparam logic FUNC_CLASSIFY   = 1'b1;
    localparam logic REG_NUM_CENTERS = 1'b0;

    typedef logic [N_ELEMS-1:0][ELEM_BITS-1:0] t_elem_vec;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic load_we;
        logic issue;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/nearest_center_classifier.sv -----
// ----------------------------------------------------------------------------
// Nearest-center classifier top level
// Finds the stored center with the smallest squared distance to a pose.
// ----------------------------------------------------------------------------
// num_centers saturates at MAX_CENTERS to give the search length. The center loop reads one
// row of the center store per cycle into nine squarers, and only one search runs at a time:
// a new request is taken only after the previous result has moved to the result register.
// Reset is synchronous and active low; it clears the control state and num_centers.
// The center store is not cleared: a slot must be loaded before it is searched.
module nearest_center_classifier #(
    parameter int MAX_CENTERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: center_slot[3:0], pose_elem_0..pose_elem_8 (16 bits each), 4 unused bits.
    input  logic [ncc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: func.
    input  logic [0:0]  i_s_tuser,
    // Master stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: nearest_index[3:0], min_distance_sq[39:4].
    output logic [ncc_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [ncc_pkg::APB_AW-1:0] i_paddr,
    input  logic [ncc_pkg::APB_DW-1:0] i_pwdata,
    output logic [ncc_pkg::APB_DW-1:0] o_prdata,
    output logic        o_pready
);
    import ncc_pkg::*;

    localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);

    logic [NUMC_W-1:0]    r_num_centers;
    logic                 w_reg_sel;
    t_elem_vec            w_elems;
    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic [IDX_W-1:0]     w_rd_addr;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [IDX_OUT_W-1:0] w_nearest_index;
    logic [DIST_W-1:0]    w_min_distance_sq;

    assign o_pready  = 1'b1;
    assign w_reg_sel = (i_paddr[2] == REG_NUM_CENTERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_centers <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_reg_sel) begin
            r_num_centers <= i_pwdata[NUMC_W-1:0];
        end
    end

    assign o_prdata = w_reg_sel ? {{(APB_DW - NUMC_W){1'b0}}, r_num_centers} : '0;

    always_comb begin
        for (int e = 0; e < N_ELEMS; e++) begin
            w_elems[e] = i_s_tdata[SLOT_W + e*ELEM_BITS +: ELEM_BITS];
        end
    end

    ncc_ctrl #(
        .MAX_CENTERS (MAX_CENTERS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_func        (i_s_tuser[0]),
        .i_slot        (i_s_tdata[SLOT_W-1:0]),
        .i_num_centers (r_num_centers),
        .i_stat        (w_stat),
        .o_s_tready    (o_s_tready),
        .o_cmd         (w_cmd),
        .o_rd_addr     (w_rd_addr),
        .o_wr_addr     (w_wr_addr)
    );

    ncc_dp #(
        .MAX_CENTERS (MAX_CENTERS),
        .IDX_W       (IDX_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_rd_addr         (w_rd_addr),
        .i_wr_addr         (w_wr_addr),
        .i_elems           (w_elems),
        .i_m_tready        (i_m_tready),
        .o_stat            (w_stat),
        .o_m_tvalid        (o_m_tvalid),
        .o_nearest_index   (w_nearest_index),
        .o_min_distance_sq (w_min_distance_sq)
    );

    assign o_m_tdata = {w_min_distance_sq, w_nearest_index};

endmodule

// ----- design/ncc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Nearest-center classifier controller
// Accepts requests, sequences center reads and hands results to the output.
// ----------------------------------------------------------------------------
module ncc_ctrl #(
    parameter int MAX_CENTERS = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_func,
    input  logic [ncc_pkg::SLOT_W-1:0] i_slot,
    input  logic [ncc_pkg::NUMC_W-1:0] i_num_centers,
    input  ncc_pkg::t_dp_stat        i_stat,
    output logic                     o_s_tready,
    output ncc_pkg::t_dp_cmd         o_cmd,
    output logic [IDX_W-1:0]         o_rd_addr,
    output logic [IDX_W-1:0]         o_wr_addr
);
    import ncc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic             w_accept;
    logic             w_slot_ok;

    assign w_accept  = i_s_tvalid && (r_state == ST_IDLE);
    assign w_slot_ok = ({{(32 - SLOT_W){1'b0}}, i_slot} < 32'(MAX_CENTERS));
    assign o_rd_addr = r_cnt[IDX_W-1:0];
    assign o_wr_addr = IDX_W'(i_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_limit <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_limit <= n_limit;
        end
    end

    // Next state, center counter and search length.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_limit = r_limit;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_func == FUNC_CLASSIFY) begin
                    n_state = ST_ISSUE;
                    n_cnt   = '0;
                    if ({{(32 - NUMC_W){1'b0}}, i_num_centers} > 32'(MAX_CENTERS)) begin
                        n_limit = CNT_W'(MAX_CENTERS);
                    end else begin
                        n_limit = CNT_W'(i_num_centers);
                    end
                end
            end
            ST_ISSUE: begin
                if (r_cnt < r_limit) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.start   = w_accept && i_func == FUNC_CLASSIFY;
                o_cmd.load_we = w_accept && i_func == FUNC_LOAD && w_slot_ok;
            end
            ST_ISSUE: begin
                o_cmd.issue = r_cnt < r_limit;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_OUT: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_cnt < r_limit && r_limit <= CNT_W'(MAX_CENTERS)))
        else $error("center read issued beyond the search length");

    a_push_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!i_stat.pipe_busy && $past(r_state) != ST_ISSUE))
        else $error("result pushed while distances are still in flight");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_ISSUE && r_cnt == '0))
        else $error("classify request did not start the search");

    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (!o_s_tready && !o_cmd.load_we && !o_cmd.start))
        else $error("request taken while a search is running");

endmodule

// ----- design/ncc_dp.sv -----
// ----------------------------------------------------------------------------
// Nearest-center classifier datapath
// Center store, nine squarers, adder stages, running minimum and result register.
// ----------------------------------------------------------------------------
module ncc_dp #(
    parameter int MAX_CENTERS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ncc_pkg::t_dp_cmd            i_cmd,
    input  logic [IDX_W-1:0]            i_rd_addr,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  ncc_pkg::t_elem_vec          i_elems,
    input  logic                        i_m_tready,
    output ncc_pkg::t_dp_stat           o_stat,
    output logic                        o_m_tvalid,
    output logic [ncc_pkg::IDX_OUT_W-1:0] o_nearest_index,
    output logic [ncc_pkg::DIST_W-1:0]  o_min_distance_sq
);
    import ncc_pkg::*;

    t_elem_vec                    r_mem [MAX_CENTERS];
    t_elem_vec                    r_pose;
    t_elem_vec                    r_rd_data;
    logic [N_ELEMS-1:0][SQ_W-1:0] r_sq;
    logic [N_ELEMS-1:0][SQ_W-1:0] n_sq;
    logic [2:0][PSUM_W-1:0]       r_psum;
    logic [DIST_W-1:0]            r_total;
    logic                         r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]             r_i1, r_i2, r_i3, r_i4;
    logic                         r_found;
    logic [IDX_W-1:0]             r_best_idx;
    logic [DIST_W-1:0]            r_best_dist;
    logic                         r_out_valid;
    logic [IDX_OUT_W-1:0]         r_out_idx;
    logic [DIST_W-1:0]            r_out_dist;

    // Center store: one row of nine elements per slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[i_wr_addr] <= i_elems;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_cmd.start) begin
            r_pose <= i_elems;
        end
    end

    // Element differences are 17 bits; their magnitude always fits in 16.
    always_comb begin
        logic signed [ELEM_BITS:0] diff;
        logic        [ELEM_BITS:0] mag;
        for (int e = 0; e < N_ELEMS; e++) begin
            diff = $signed({r_pose[e][ELEM_BITS-1], r_pose[e]})
                 - $signed({r_rd_data[e][ELEM_BITS-1], r_rd_data[e]});
            mag  = diff[ELEM_BITS] ? (~diff + 1'b1) : diff;
            n_sq[e] = SQ_W'(mag[MAG_W-1:0]) * SQ_W'(mag[MAG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq  <= n_sq;
        for (int k = 0; k < 3; k++) begin
            r_psum[k] <= PSUM_W'(r_sq[3*k]) + PSUM_W'(r_sq[3*k+1]) + PSUM_W'(r_sq[3*k+2]);
        end
        r_total <= DIST_W'(r_psum[0]) + DIST_W'(r_psum[1]) + DIST_W'(r_psum[2]);
        r_i1 <= i_rd_addr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Running minimum; a strict compare keeps the lower index on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_found <= 1'b0;
        end else if (r_v4) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (i_cmd.start) begin
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (r_v4 && (!r_found || r_total < r_best_dist)) begin
            r_best_idx  <= r_i4;
            r_best_dist <= r_total;
        end
    end

    // Result register decouples the search from the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_idx  <= IDX_OUT_W'(r_best_idx);
            r_out_dist <= r_best_dist;
        end
    end

    assign o_stat.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_stat.out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_nearest_index   = r_out_idx;
    assign o_min_distance_sq = r_out_dist;

    a_push_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before it was taken");

    a_best_only_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v4 && !i_cmd.start) |=> ($stable(r_best_dist) && $stable(r_best_idx)))
        else $error("running minimum changed without a new distance");

endmodule
